@@ hw/rtl/mtoc_pkg.sv @@
// Shared types and codes for the MAC timer with overflow compare.
`default_nettype none

package mtoc_pkg;

  // Number of event flag bits.
  localparam int NUM_FLAGS = 6;

  // Item actions.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Byte window addresses.
  localparam logic [2:0] ADDR_CTRL   = 3'd0;
  localparam logic [2:0] ADDR_MUX    = 3'd1;
  localparam logic [2:0] ADDR_LOW    = 3'd2;
  localparam logic [2:0] ADDR_HIGH   = 3'd3;
  localparam logic [2:0] ADDR_OVF_B0 = 3'd4;
  localparam logic [2:0] ADDR_OVF_B1 = 3'd5;
  localparam logic [2:0] ADDR_OVF_B2 = 3'd6;
  localparam logic [2:0] ADDR_FLAGS  = 3'd7;

  // Register selector codes behind the byte window.
  localparam logic [2:0] SEL_MAIN   = 3'd0;
  localparam logic [2:0] SEL_PERIOD = 3'd2;
  localparam logic [2:0] SEL_CMP1   = 3'd3;
  localparam logic [2:0] SEL_CMP2   = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IRQ_MASK = 2'd0;
  localparam logic [1:0] CFG_EVENT1   = 2'd1;
  localparam logic [1:0] CFG_EVENT2   = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0] action;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] read_data;
    logic [5:0] irq_flags;
    logic       event_one;
    logic       event_two;
    logic       interrupt_request;
    logic       overflow_pulse;
  } result_t;

  // Flag bit routed to an event output; selectors past the last flag never fire.
  function automatic logic pick_flag(input logic [5:0] flags, input logic [2:0] sel);
    logic bit_val;
    bit_val = 1'b0;
    if (sel < 3'(NUM_FLAGS)) begin
      bit_val = flags[sel];
    end
    return bit_val;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mtoc_in_if.sv @@
// Input channel of the timer: valid/ready handshake with the item fields.
`default_nettype none

interface mtoc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] reg_addr;
  logic [7:0] write_data;

  modport source (output valid, output action, output reg_addr, output write_data,
                  input ready);
  modport sink (input valid, input action, input reg_addr, input write_data,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mtoc_out_if.sv @@
// Result channel of the timer: valid/ready handshake with the result fields.
`default_nettype none

interface mtoc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [5:0] irq_flags;
  logic       event_one;
  logic       event_two;
  logic       interrupt_request;
  logic       overflow_pulse;

  modport source (output valid, output read_data, output irq_flags, output event_one,
                  output event_two, output interrupt_request, output overflow_pulse,
                  input ready);
  modport sink (input valid, input read_data, input irq_flags, input event_one,
                input event_two, input interrupt_request, input overflow_pulse,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mac_timer_with_overflow_compare_core.sv @@
// Top level of the MAC timer with overflow counter and compare flags.
//
//   Channel    Direction  Carries
//   item_ch    in         action, reg_addr, write_data (tick, byte write, byte read)
//   result_ch  out        read_data, irq_flags, event_one/two, interrupt_request,
//                         overflow_pulse (one result per item)
//   cfg_*      in         irq_mask, event1_select, event2_select writes
//
// One item is taken per cycle while the result channel keeps up; each item passes
// through the input register, then the update into the result register, from which
// its result transfers.
// The rate is set by the counter step and compare logic in the engine.
// Reset is synchronous and clears all timer state and configuration to zero.
// A stalled result channel holds the result register and, one item later, the
// input register; item_ch.ready drops only when both are full.
`default_nettype none

module mac_timer_with_overflow_compare_core #(
  parameter int COUNT_BITS    = 16,
  parameter int OVERFLOW_BITS = 24
) (
  input  wire logic       clk,
  input  wire logic       rst,
  mtoc_in_if.sink         item_ch,
  mtoc_out_if.source      result_ch,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [5:0] cfg_data
);
  import mtoc_pkg::*;

  logic    held_valid;
  item_t   held_item;
  logic    out_space;
  logic    step;
  result_t result;

  // The held item is processed when the result register can take its result.
  assign step = held_valid && out_space;

  mtoc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item_ch    (item_ch),
    .take       (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  mtoc_engine #(
    .COUNT_BITS    (COUNT_BITS),
    .OVERFLOW_BITS (OVERFLOW_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (held_item),
    .result    (result)
  );

  mtoc_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .result    (result),
    .space     (out_space),
    .result_ch (result_ch)
  );

endmodule

`default_nettype wire

@@ hw/rtl/mtoc_in_stage.sv @@
// Input register that holds one item until the engine takes it.
`default_nettype none

module mtoc_in_stage (
  input  wire logic         clk,
  input  wire logic         rst,
  mtoc_in_if.sink           item_ch,
  input  wire logic         take,
  output logic              held_valid,
  output mtoc_pkg::item_t   held_item
);
  import mtoc_pkg::*;

  // Room for a new transfer when empty or when the held item leaves now.
  assign item_ch.ready = !held_valid || take;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ch.valid && item_ch.ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (item_ch.valid && item_ch.ready) begin
      held_item.action     <= item_ch.action;
      held_item.reg_addr   <= item_ch.reg_addr;
      held_item.write_data <= item_ch.write_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mtoc_engine.sv @@
// Timer state, configuration registers and the per-item update logic.
`default_nettype none

module mtoc_engine #(
  parameter int COUNT_BITS    = 16,
  parameter int OVERFLOW_BITS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [5:0]    cfg_data,
  input  wire logic          step,
  input  wire mtoc_pkg::item_t item,
  output mtoc_pkg::result_t  result
);
  import mtoc_pkg::*;

  // Configuration registers.
  logic [5:0] irq_mask;
  logic [2:0] event1_select;
  logic [2:0] event2_select;

  // Timer state.
  logic [COUNT_BITS-1:0]    counter, counter_next;
  logic [COUNT_BITS-1:0]    compare_one, compare_one_next;
  logic [COUNT_BITS-1:0]    compare_two, compare_two_next;
  logic [COUNT_BITS-1:0]    period_value, period_value_next;
  logic [OVERFLOW_BITS-1:0] overflow_count, overflow_count_next;
  logic [OVERFLOW_BITS-1:0] overflow_period, overflow_period_next;
  logic [OVERFLOW_BITS-1:0] overflow_compare_one, overflow_compare_one_next;
  logic [OVERFLOW_BITS-1:0] overflow_compare_two, overflow_compare_two_next;
  logic [7:0]               low_byte_latch, low_byte_latch_next;
  logic [7:0]               mux_select, mux_select_next;
  logic                     run_flag, run_flag_next;
  logic                     delta_mode, delta_mode_next;
  logic [5:0]               flag_bits, flag_bits_next;

  // Tick path signals.
  logic [COUNT_BITS-1:0]    cnt_inc, cnt_dec, cnt_step;
  logic                     cnt_zero, wrap;
  logic                     match_one, match_two, match_period, bump;
  logic [OVERFLOW_BITS-1:0] ovf_inc, ovf_after;
  logic                     ovf_hit, ovf_cmp_one, ovf_cmp_two;
  logic [5:0]               raised;

  // Byte window signals.
  logic [2:0]               cnt_sel, ovf_sel;
  logic [COUNT_BITS-1:0]    cnt_rd_sel, cnt_wr_val;
  logic [OVERFLOW_BITS-1:0] ovf_rd_sel, ovf_wr_val;
  logic [31:0]              cnt_wide, ovf_wide, ovf_merged, ovf_rd_shift;
  logic [4:0]               byte_shift;

  // Result signals.
  logic [7:0]               read_data;
  logic                     irq;
  logic                     pulse;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_mask      <= '0;
      event1_select <= '0;
      event2_select <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IRQ_MASK: irq_mask      <= cfg_data;
        CFG_EVENT1:   event1_select <= cfg_data[2:0];
        CFG_EVENT2:   event2_select <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // One counter step: up with wrap, or down in delta mode until zero.
  always_comb begin
    cnt_inc  = counter + 1'b1;
    cnt_dec  = counter - 1'b1;
    cnt_zero = (counter == '0);
    if (!delta_mode) begin
      cnt_step = cnt_inc;
      wrap     = (cnt_inc == '0);
    end else begin
      cnt_step = cnt_zero ? counter : cnt_dec;
      wrap     = 1'b0;
    end
  end

  // Compare and period matches on the stepped counter.
  assign match_one    = (cnt_step == compare_one);
  assign match_two    = (cnt_step == compare_two);
  assign match_period = (cnt_step == period_value) && (period_value != '0);
  // A wrap leaves zero, which never meets a nonzero period, so one bump at most.
  assign bump         = wrap || match_period;

  // Overflow counter bump with its own period and compares.
  assign ovf_inc     = overflow_count + 1'b1;
  assign ovf_hit     = (ovf_inc == overflow_period);
  assign ovf_after   = ovf_hit ? '0 : ovf_inc;
  assign ovf_cmp_one = (ovf_after == overflow_compare_one);
  assign ovf_cmp_two = (ovf_after == overflow_compare_two);

  assign raised = {bump && ovf_cmp_two, bump && ovf_cmp_one, bump && ovf_hit,
                   match_two, match_one, match_period};

  // Registers behind the byte window.
  assign cnt_sel = mux_select[2:0];
  assign ovf_sel = mux_select[6:4];

  always_comb begin
    unique case (cnt_sel)
      SEL_MAIN:   cnt_rd_sel = counter;
      SEL_PERIOD: cnt_rd_sel = period_value;
      SEL_CMP1:   cnt_rd_sel = compare_one;
      SEL_CMP2:   cnt_rd_sel = compare_two;
      default:    cnt_rd_sel = '0;
    endcase
    unique case (ovf_sel)
      SEL_MAIN:   ovf_rd_sel = overflow_count;
      SEL_PERIOD: ovf_rd_sel = overflow_period;
      SEL_CMP1:   ovf_rd_sel = overflow_compare_one;
      SEL_CMP2:   ovf_rd_sel = overflow_compare_two;
      default:    ovf_rd_sel = '0;
    endcase
  end

  // Write values: low byte alone or high byte over the latched low byte.
  assign cnt_wr_val = (item.reg_addr == ADDR_LOW) ? COUNT_BITS'(item.write_data)
                                                  : COUNT_BITS'({item.write_data,
                                                                 low_byte_latch});
  assign cnt_wide   = 32'(cnt_rd_sel);

  // Overflow bytes: one byte replaced in place, bytes past the width dropped.
  assign byte_shift   = {item.reg_addr[1:0], 3'b000};
  assign ovf_wide     = 32'(ovf_rd_sel);
  assign ovf_merged   = (ovf_wide & ~(32'h0000_00FF << byte_shift))
                        | (32'(item.write_data) << byte_shift);
  assign ovf_wr_val   = OVERFLOW_BITS'(ovf_merged);
  assign ovf_rd_shift = ovf_wide >> byte_shift;

  // Next state and result for the item in hand.
  always_comb begin
    counter_next              = counter;
    compare_one_next          = compare_one;
    compare_two_next          = compare_two;
    period_value_next         = period_value;
    overflow_count_next       = overflow_count;
    overflow_period_next      = overflow_period;
    overflow_compare_one_next = overflow_compare_one;
    overflow_compare_two_next = overflow_compare_two;
    low_byte_latch_next       = low_byte_latch;
    mux_select_next           = mux_select;
    run_flag_next             = run_flag;
    delta_mode_next           = delta_mode;
    flag_bits_next            = flag_bits;
    read_data                 = '0;
    irq                       = 1'b0;
    pulse                     = 1'b0;

    unique case (item.action)
      ACT_TICK: begin
        counter_next = match_period ? '0 : cnt_step;
        if (delta_mode && cnt_zero) begin
          delta_mode_next = 1'b0;
        end
        if (bump) begin
          overflow_count_next = ovf_after;
        end
        // A tick with no match clears every flag.
        flag_bits_next = (raised != '0) ? (flag_bits | raised) : '0;
        irq            = |(raised & irq_mask);
        pulse          = bump;
      end
      ACT_WRITE: begin
        unique case (item.reg_addr) inside
          ADDR_CTRL: run_flag_next   = item.write_data[0];
          ADDR_MUX:  mux_select_next = item.write_data;
          ADDR_LOW, ADDR_HIGH: begin
            if (item.reg_addr == ADDR_LOW) begin
              low_byte_latch_next = item.write_data;
            end
            unique case (cnt_sel)
              SEL_MAIN: begin
                counter_next = cnt_wr_val;
                // Loading the counter's high byte while running switches to counting down.
                if (item.reg_addr == ADDR_HIGH && run_flag) begin
                  delta_mode_next = 1'b1;
                end
              end
              SEL_PERIOD: period_value_next = cnt_wr_val;
              SEL_CMP1:   compare_one_next  = cnt_wr_val;
              SEL_CMP2:   compare_two_next  = cnt_wr_val;
              default: ;
            endcase
          end
          ADDR_OVF_B0, ADDR_OVF_B1, ADDR_OVF_B2: begin
            unique case (ovf_sel)
              SEL_MAIN:   overflow_count_next       = ovf_wr_val;
              SEL_PERIOD: overflow_period_next      = ovf_wr_val;
              SEL_CMP1:   overflow_compare_one_next = ovf_wr_val;
              SEL_CMP2:   overflow_compare_two_next = ovf_wr_val;
              default: ;
            endcase
          end
          ADDR_FLAGS: flag_bits_next = item.write_data[5:0];
          default: ;
        endcase
      end
      ACT_READ: begin
        unique case (item.reg_addr) inside
          ADDR_CTRL:  read_data = {7'b0, run_flag};
          ADDR_MUX:   read_data = mux_select;
          ADDR_LOW:   read_data = cnt_wide[7:0];
          ADDR_HIGH:  read_data = cnt_wide[15:8];
          ADDR_OVF_B0, ADDR_OVF_B1, ADDR_OVF_B2: read_data = ovf_rd_shift[7:0];
          ADDR_FLAGS: read_data = {2'b0, flag_bits};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // State update when an item is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      counter              <= '0;
      compare_one          <= '0;
      compare_two          <= '0;
      period_value         <= '0;
      overflow_count       <= '0;
      overflow_period      <= '0;
      overflow_compare_one <= '0;
      overflow_compare_two <= '0;
      low_byte_latch       <= '0;
      mux_select           <= '0;
      run_flag             <= 1'b0;
      delta_mode           <= 1'b0;
      flag_bits            <= '0;
    end else if (step) begin
      counter              <= counter_next;
      compare_one          <= compare_one_next;
      compare_two          <= compare_two_next;
      period_value         <= period_value_next;
      overflow_count       <= overflow_count_next;
      overflow_period      <= overflow_period_next;
      overflow_compare_one <= overflow_compare_one_next;
      overflow_compare_two <= overflow_compare_two_next;
      low_byte_latch       <= low_byte_latch_next;
      mux_select           <= mux_select_next;
      run_flag             <= run_flag_next;
      delta_mode           <= delta_mode_next;
      flag_bits            <= flag_bits_next;
    end
  end

  // Result fields follow the flags as they stand after this item.
  assign result.read_data         = read_data;
  assign result.irq_flags         = flag_bits_next;
  assign result.event_one         = pick_flag(flag_bits_next, event1_select);
  assign result.event_two         = pick_flag(flag_bits_next, event2_select);
  assign result.interrupt_request = irq;
  assign result.overflow_pulse    = pulse;

endmodule

`default_nettype wire

@@ hw/rtl/mtoc_out_stage.sv @@
// Result register that drives the result channel.
`default_nettype none

module mtoc_out_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire mtoc_pkg::result_t result,
  output logic                 space,
  mtoc_out_if.source           result_ch
);
  import mtoc_pkg::*;

  logic    res_valid;
  result_t res_data;

  // A new result may enter when empty or when the current one transfers now.
  assign space = !res_valid || result_ch.ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (load) begin
      res_data <= result;
    end
  end

  assign result_ch.valid             = res_valid;
  assign result_ch.read_data         = res_data.read_data;
  assign result_ch.irq_flags         = res_data.irq_flags;
  assign result_ch.event_one         = res_data.event_one;
  assign result_ch.event_two         = res_data.event_two;
  assign result_ch.interrupt_request = res_data.interrupt_request;
  assign result_ch.overflow_pulse    = res_data.overflow_pulse;

endmodule

`default_nettype wire

@@ test/tb_mac_timer_with_overflow_compare_core.sv @@
// Testbench for the MAC timer core: directed table, then random bursts checked against a timer model.
module tb_mac_timer_with_overflow_compare_core;
  import mtoc_pkg::*;

  // No action code exists for the unused fourth value; the block ignores it.
  localparam logic [1:0] ACT_NONE = 2'd3;

  // Flag bits raised by the timer.
  localparam logic [5:0] FLAG_PERIOD     = 6'h01;
  localparam logic [5:0] FLAG_CMP1       = 6'h02;
  localparam logic [5:0] FLAG_CMP2       = 6'h04;
  localparam logic [5:0] FLAG_OVF_PERIOD = 6'h08;
  localparam logic [5:0] FLAG_OVF_CMP1   = 6'h10;
  localparam logic [5:0] FLAG_OVF_CMP2   = 6'h20;

  localparam int DIR_ROWS       = 27;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 105;
  localparam int LONG_HOLD      = 60;
  localparam int PHASE_PAD      = 4;
  localparam int END_PAD        = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  // One row of the directed table; want is used only where fixed is set.
  typedef struct packed {
    item_t   stim;
    logic    fixed;
    result_t want;
  } dir_row_t;

  localparam result_t NO_WANT = '0;

  logic clk;
  logic rst;
  logic       cfg_wr_en;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;

  mtoc_in_if  item_if ();
  mtoc_out_if result_if ();

  mac_timer_with_overflow_compare_core dut (
    .clk       (clk),
    .rst       (rst),
    .item_ch   (item_if),
    .result_ch (result_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Directed stimulus, run with all configuration registers at zero.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{ACT_TICK,  ADDR_CTRL,   8'h00}, 1'b1, '{8'h00, 6'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_WRITE, ADDR_CTRL,   8'hFF}, 1'b1, '{8'h00, 6'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_READ,  ADDR_CTRL,   8'h00}, 1'b1, '{8'h01, 6'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
    // Window on period and overflow period; period three, overflow period two.
    '{'{ACT_WRITE, ADDR_MUX,    8'h22}, 1'b0, NO_WANT},
    '{'{ACT_WRITE, ADDR_LOW,    8'h03}, 1'b0, NO_WANT},
    '{'{ACT_WRITE, ADDR_HIGH,   8'h00}, 1'b0, NO_WANT},
    '{'{ACT_WRITE, ADDR_OVF_B0, 8'h02}, 1'b0, NO_WANT},
    '{'{ACT_READ,  ADDR_MUX,    8'h00}, 1'b1, '{8'h22, 6'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
    // Two period matches; the second also hits the overflow period and compares.
    '{'{ACT_TICK,  ADDR_CTRL,   8'h00}, 1'b0, NO_WANT},
    '{'{ACT_TICK,  ADDR_CTRL,   8'h00}, 1'b0, NO_WANT},
    '{'{ACT_TICK,  ADDR_CTRL,   8'h00}, 1'b0, NO_WANT},
    '{'{ACT_TICK,  ADDR_CTRL,   8'h00}, 1'b0, NO_WANT},
    '{'{ACT_TICK,  ADDR_CTRL,   8'h00}, 1'b0, NO_WANT},
    '{'{ACT_WRITE, ADDR_FLAGS,  8'hFF}, 1'b1, '{8'h00, 6'h3F, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{'{ACT_READ,  ADDR_FLAGS,  8'h00}, 1'b1, '{8'h3F, 6'h3F, 1'b1, 1'b1, 1'b0, 1'b0}},
    // Unused selectors on both halves of the window; an overflow byte reads as zero.
    '{'{ACT_WRITE, ADDR_MUX,    8'h77}, 1'b0, NO_WANT},
    '{'{ACT_READ,  ADDR_OVF_B2, 8'h00}, 1'b1, '{8'h00, 6'h3F, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{'{ACT_NONE,  ADDR_FLAGS,  8'hFF}, 1'b1, '{8'h00, 6'h3F, 1'b1, 1'b1, 1'b0, 1'b0}},
    // Counter loaded with zero while running: down mode, then back to up mode.
    '{'{ACT_WRITE, ADDR_MUX,    8'h00}, 1'b0, NO_WANT},
    '{'{ACT_WRITE, ADDR_LOW,    8'h00}, 1'b0, NO_WANT},
    '{'{ACT_WRITE, ADDR_HIGH,   8'h00}, 1'b0, NO_WANT},
    '{'{ACT_TICK,  ADDR_CTRL,   8'h00}, 1'b0, NO_WANT},
    // Stopped counter loaded with all ones, then wraps on the next tick.
    '{'{ACT_WRITE, ADDR_CTRL,   8'h00}, 1'b0, NO_WANT},
    '{'{ACT_WRITE, ADDR_LOW,    8'hFF}, 1'b0, NO_WANT},
    '{'{ACT_WRITE, ADDR_HIGH,   8'hFF}, 1'b0, NO_WANT},
    '{'{ACT_TICK,  ADDR_CTRL,   8'h00}, 1'b0, NO_WANT},
    '{'{ACT_WRITE, ADDR_OVF_B2, 8'hFF}, 1'b0, NO_WANT}
  };

  // Per-phase configuration.
  int unsigned ph_mask [NUM_PHASES] = '{63, 42, 21, 1, 48, 0};
  int unsigned ph_ev1  [NUM_PHASES] = '{7, 3, 0, 5, 6, 4};
  int unsigned ph_ev2  [NUM_PHASES] = '{6, 1, 2, 4, 0, 7};

  // Timer model state.
  logic [15:0] tm_count = '0;
  logic [15:0] tm_cmp1 = '0;
  logic [15:0] tm_cmp2 = '0;
  logic [15:0] tm_period = '0;
  logic [23:0] tm_ovf = '0;
  logic [23:0] tm_ovf_period = '0;
  logic [23:0] tm_ovf_cmp1 = '0;
  logic [23:0] tm_ovf_cmp2 = '0;
  logic [7:0]  tm_latch = '0;
  logic [7:0]  tm_mux = '0;
  logic        tm_run = 1'b0;
  logic        tm_down = 1'b0;
  logic [5:0]  tm_flags = '0;
  logic [5:0]  cfg_mask = '0;
  logic [2:0]  cfg_ev1 = '0;
  logic [2:0]  cfg_ev2 = '0;
  logic [5:0]  tick_raised;
  logic        tick_pulse;

  result_t timer_results_due [$];
  int      items_taken = 0;
  int      err_count = 0;
  int      snd_idle_pct;
  int      rcv_idle_pct;
  logic    long_hold_req = 1'b0;
  logic    long_hold_done = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void raise_flag(input logic [5:0] flag);
    tm_flags    = tm_flags | flag;
    tick_raised = tick_raised | flag;
  endfunction

  // Overflow counter step with its period and compare checks.
  function automatic void bump_ovf();
    tick_pulse = 1'b1;
    tm_ovf = tm_ovf + 24'd1;
    if (tm_ovf == tm_ovf_period) begin
      tm_ovf = '0;
      raise_flag(FLAG_OVF_PERIOD);
    end
    if (tm_ovf == tm_ovf_cmp1) raise_flag(FLAG_OVF_CMP1);
    if (tm_ovf == tm_ovf_cmp2) raise_flag(FLAG_OVF_CMP2);
  endfunction

  function automatic logic [15:0] count_reg_rd(input logic [2:0] sel);
    case (sel)
      SEL_MAIN:   return tm_count;
      SEL_PERIOD: return tm_period;
      SEL_CMP1:   return tm_cmp1;
      SEL_CMP2:   return tm_cmp2;
      default:    return '0;
    endcase
  endfunction

  function automatic void count_reg_wr(input logic [2:0] sel, input logic [15:0] val);
    case (sel)
      SEL_MAIN:   tm_count = val;
      SEL_PERIOD: tm_period = val;
      SEL_CMP1:   tm_cmp1 = val;
      SEL_CMP2:   tm_cmp2 = val;
      default: ;
    endcase
  endfunction

  function automatic logic [23:0] ovf_reg_rd(input logic [2:0] sel);
    case (sel)
      SEL_MAIN:   return tm_ovf;
      SEL_PERIOD: return tm_ovf_period;
      SEL_CMP1:   return tm_ovf_cmp1;
      SEL_CMP2:   return tm_ovf_cmp2;
      default:    return '0;
    endcase
  endfunction

  // Applies one item to the timer model and returns the result it should produce.
  function automatic result_t next_timer_result(input item_t it);
    result_t     r;
    logic [15:0] cv;
    logic [23:0] ov;
    logic [1:0]  bsel;
    r = '0;
    tick_raised = '0;
    tick_pulse = 1'b0;
    bsel = 2'(it.reg_addr - ADDR_OVF_B0);
    case (it.action)
      ACT_TICK: begin
        if (!tm_down) begin
          tm_count = tm_count + 16'd1;
          if (tm_count == '0) bump_ovf();
        end else if (tm_count == '0) begin
          tm_down = 1'b0;
        end else begin
          tm_count = tm_count - 16'd1;
        end
        if (tm_count == tm_cmp1) raise_flag(FLAG_CMP1);
        if (tm_count == tm_cmp2) raise_flag(FLAG_CMP2);
        if (tm_count == tm_period && tm_period != '0) begin
          tm_count = '0;
          bump_ovf();
          raise_flag(FLAG_PERIOD);
        end
        // A tick without any match clears every flag.
        if (tick_raised == '0) tm_flags = '0;
        r.interrupt_request = |(tick_raised & cfg_mask);
      end
      ACT_WRITE: begin
        case (it.reg_addr)
          ADDR_CTRL: tm_run = it.write_data[0];
          ADDR_MUX:  tm_mux = it.write_data;
          ADDR_LOW: begin
            tm_latch = it.write_data;
            count_reg_wr(tm_mux[2:0], {8'h00, it.write_data});
          end
          ADDR_HIGH: begin
            count_reg_wr(tm_mux[2:0], {it.write_data, tm_latch});
            // Loading the running counter switches it to counting down.
            if (tm_mux[2:0] == SEL_MAIN && tm_run) tm_down = 1'b1;
          end
          ADDR_FLAGS: tm_flags = it.write_data[5:0];
          default: begin
            ov = ovf_reg_rd(tm_mux[6:4]);
            ov[bsel*8 +: 8] = it.write_data;
            case (tm_mux[6:4])
              SEL_MAIN:   tm_ovf = ov;
              SEL_PERIOD: tm_ovf_period = ov;
              SEL_CMP1:   tm_ovf_cmp1 = ov;
              SEL_CMP2:   tm_ovf_cmp2 = ov;
              default: ;
            endcase
          end
        endcase
      end
      ACT_READ: begin
        cv = count_reg_rd(tm_mux[2:0]);
        ov = ovf_reg_rd(tm_mux[6:4]);
        case (it.reg_addr)
          ADDR_CTRL:  r.read_data = {7'd0, tm_run};
          ADDR_MUX:   r.read_data = tm_mux;
          ADDR_LOW:   r.read_data = cv[7:0];
          ADDR_HIGH:  r.read_data = cv[15:8];
          ADDR_FLAGS: r.read_data = {2'b00, tm_flags};
          default:    r.read_data = ov[bsel*8 +: 8];
        endcase
      end
      default: ;
    endcase
    r.irq_flags      = tm_flags;
    r.event_one      = (cfg_ev1 < 3'(NUM_FLAGS)) ? tm_flags[cfg_ev1] : 1'b0;
    r.event_two      = (cfg_ev2 < 3'(NUM_FLAGS)) ? tm_flags[cfg_ev2] : 1'b0;
    r.overflow_pulse = tick_pulse;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // Checks each result transfer, then records the expected result of each item transfer.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    item_t   it;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        got = '{result_if.read_data, result_if.irq_flags, result_if.event_one,
                result_if.event_two, result_if.interrupt_request, result_if.overflow_pulse};
        if (timer_results_due.size() == 0) begin
          $error("result transfer with no result due: 0x%0h", got);
          err_count++;
        end else begin
          want = timer_results_due.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("irq_flags", want.irq_flags, got.irq_flags);
          check_field("event_one", want.event_one, got.event_one);
          check_field("event_two", want.event_two, got.event_two);
          check_field("interrupt_request", want.interrupt_request, got.interrupt_request);
          check_field("overflow_pulse", want.overflow_pulse, got.overflow_pulse);
        end
      end
      if (item_if.valid && item_if.ready) begin
        it = '{item_if.action, item_if.reg_addr, item_if.write_data};
        want = next_timer_result(it);
        if (items_taken < DIR_ROWS && dir_tab[items_taken].fixed) want = dir_tab[items_taken].want;
        timer_results_due.push_back(want);
        items_taken++;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off that backs up the input.
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done  <= 1'b1;
      hold_left       <= LONG_HOLD;
      result_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item, with an optional random gap before it, and waits for its transfer.
  task automatic send_item(input logic [1:0] act, input logic [2:0] addr,
                           input logic [7:0] data);
    if ($urandom_range(99) < snd_idle_pct) begin
      item_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    item_if.valid      <= 1'b1;
    item_if.action     <= act;
    item_if.reg_addr   <= addr;
    item_if.write_data <= data;
    do @(posedge clk); while (!item_if.ready);
  endtask

  // Waits until every expected result has arrived, then for the given padding.
  task automatic drain(input int pad);
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (timer_results_due.size() != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  // Writes all three configuration registers on consecutive cycles.
  task automatic program_cfg(input logic [5:0] mask, input logic [2:0] ev1,
                             input logic [2:0] ev2);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IRQ_MASK;
    cfg_data  <= mask;
    @(posedge clk);
    cfg_index <= CFG_EVENT1;
    cfg_data  <= {3'b000, ev1};
    @(posedge clk);
    cfg_index <= CFG_EVENT2;
    cfg_data  <= {3'b000, ev2};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_mask = mask;
    cfg_ev1  = ev1;
    cfg_ev2  = ev2;
  endtask

  // Mostly the four real selectors, sometimes a random code that may be unused.
  function automatic logic [2:0] pick_sel();
    case ($urandom_range(4))
      0:       return SEL_MAIN;
      1:       return SEL_PERIOD;
      2:       return SEL_CMP1;
      3:       return SEL_CMP2;
      default: return 3'($urandom);
    endcase
  endfunction

  // One random burst: tick runs, register loads through the window, reads, noise.
  task automatic random_burst(output int n);
    int         pick;
    logic [7:0] lo;
    logic [7:0] hi;
    pick = $urandom_range(99);
    n = 1;
    if (pick < 50) begin
      n = $urandom_range(1, 12);
      repeat (n) send_item(ACT_TICK, 3'($urandom), 8'($urandom));
    end else if (pick < 72) begin
      send_item(ACT_WRITE, ADDR_MUX, {1'($urandom), pick_sel(), 1'($urandom), pick_sel()});
      if (pick < 62) begin
        // Small values keep period and compare matches within reach.
        lo = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(20));
        case ($urandom_range(7))
          0:       hi = 8'hFF;
          1:       hi = 8'($urandom);
          default: hi = 8'h00;
        endcase
        send_item(ACT_WRITE, ADDR_LOW, lo);
        send_item(ACT_WRITE, ADDR_HIGH, hi);
      end else begin
        send_item(ACT_WRITE, ADDR_OVF_B0, 8'($urandom_range(6)));
        send_item(ACT_WRITE, ADDR_OVF_B1, ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00);
        send_item(ACT_WRITE, ADDR_OVF_B2, ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00);
      end
      n = (pick < 62) ? 3 : 4;
    end else if (pick < 80) begin
      send_item(ACT_WRITE, ADDR_CTRL, 8'($urandom));
    end else if (pick < 90) begin
      send_item(ACT_READ, 3'($urandom), 8'($urandom));
    end else if (pick < 94) begin
      send_item(ACT_WRITE, ADDR_FLAGS, 8'($urandom));
    end else begin
      send_item(2'($urandom), 3'($urandom), 8'($urandom));
    end
  endtask

  // Main sequence: reset, directed table, then random phases under varying stalls.
  initial begin
    int ph;
    int sent;
    int n;
    rst = 1'b1;
    item_if.valid = 1'b0;
    item_if.action = ACT_TICK;
    item_if.reg_addr = ADDR_CTRL;
    item_if.write_data = 8'h00;
    result_if.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_IRQ_MASK;
    cfg_data = 6'h00;
    snd_idle_pct = 7;
    rcv_idle_pct = 50;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    program_cfg(6'h00, 3'd0, 3'd0);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].stim.action, dir_tab[i].stim.reg_addr, dir_tab[i].stim.write_data);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain(PHASE_PAD);
      snd_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 50 : 0;
      rcv_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 7 : 0;
      program_cfg(6'(ph_mask[ph]), 3'(ph_ev1[ph]), 3'(ph_ev2[ph]));
      if (ph == 0) long_hold_req <= 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_burst(n);
        sent += n;
      end
    end

    drain(END_PAD);
    if (err_count == 0 && timer_results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
